// ----- hw/rtl/cht_pkg.sv -----
// Shared types and constants for the color histogram search tree.
package cht_pkg;

    localparam int COLOR_W    = 24;
    localparam int COUNT_W    = 32;
    localparam int DISTINCT_W = 13;
    localparam int STATUS_W   = 2;
    localparam int BPG_W      = 4;

    localparam logic [BPG_W-1:0] BPG_MIN   = 4'd4;
    localparam logic [BPG_W-1:0] BPG_MAX   = 4'd8;
    localparam logic [BPG_W-1:0] BPG_RESET = 4'd5;

    localparam logic [7:0] CHAN_MASK = 8'hff;

    // action codes
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NODATA = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_UPDATE,
        ST_LINK,
        ST_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // take input word, start read of root
        logic step;      // descend one level, read next node
        logic take_hit;  // current node matches key
        logic bump;      // add amount to matched node and total
        logic full;      // pool exhausted
        logic claim;     // write fresh node
        logic link;      // hook fresh node to parent, bump counters
        logic emit;      // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_zero;   // incoming word is an add of zero
        logic node_ok;   // current link points at a live node
        logic hit;       // node color equals key
        logic is_query;
        logic found;
        logic pool_full;
        logic out_free;
    } t_sts;

endpackage

// ----- hw/rtl/cht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/cht_ctrl.sv -----
// Sequencer for the tree walk, update and result hand-off.
module cht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  cht_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output cht_pkg::t_cmd o_cmd
);

    cht_pkg::t_state r_state;
    cht_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cht_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cht_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_zero ? cht_pkg::ST_RESULT : cht_pkg::ST_WALK;
                end
            end
            cht_pkg::ST_WALK: begin
                if (!i_sts.node_ok || i_sts.hit) begin
                    n_state = cht_pkg::ST_UPDATE;
                end
            end
            cht_pkg::ST_UPDATE: begin
                if (!i_sts.is_query && !i_sts.found && !i_sts.pool_full) begin
                    n_state = cht_pkg::ST_LINK;
                end else begin
                    n_state = cht_pkg::ST_RESULT;
                end
            end
            cht_pkg::ST_LINK: begin
                n_state = cht_pkg::ST_RESULT;
            end
            cht_pkg::ST_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = cht_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cht_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            cht_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            cht_pkg::ST_WALK: begin
                if (i_sts.node_ok) begin
                    if (i_sts.hit) begin
                        o_cmd.take_hit = 1'b1;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            cht_pkg::ST_UPDATE: begin
                if (!i_sts.is_query) begin
                    if (i_sts.found) begin
                        o_cmd.bump = 1'b1;
                    end else if (i_sts.pool_full) begin
                        o_cmd.full = 1'b1;
                    end else begin
                        o_cmd.claim = 1'b1;
                    end
                end
            end
            cht_pkg::ST_LINK: begin
                o_cmd.link = 1'b1;
            end
            cht_pkg::ST_RESULT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/cht_dpath.sv -----
// Datapath: node memories, walk registers, counters and output register.
module cht_dpath #(
    parameter int NODE_COUNT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config
    input  logic                                i_cfg_we,
    input  logic [cht_pkg::BPG_W-1:0]           i_cfg_data,
    // input word
    input  logic                                i_action,
    input  logic [cht_pkg::COLOR_W-1:0]         i_color,
    input  logic [cht_pkg::COUNT_W-1:0]         i_amount,
    // control
    input  cht_pkg::t_cmd                       i_cmd,
    output cht_pkg::t_sts                       o_sts,
    // output word
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [cht_pkg::STATUS_W-1:0]        o_status,
    output logic [cht_pkg::COUNT_W-1:0]         o_count,
    output logic [cht_pkg::DISTINCT_W-1:0]      o_distinct,
    output logic [cht_pkg::COUNT_W-1:0]         o_total
);

    localparam int AW  = $clog2(NODE_COUNT);
    localparam int LW  = $clog2(NODE_COUNT + 1);
    localparam int CTW = cht_pkg::COLOR_W + cht_pkg::COUNT_W;
    localparam int WW  = (LW > cht_pkg::DISTINCT_W) ? LW : cht_pkg::DISTINCT_W;
    localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);

    function automatic logic [cht_pkg::COUNT_W-1:0] sat_add(
        input logic [cht_pkg::COUNT_W-1:0] a,
        input logic [cht_pkg::COUNT_W-1:0] b
    );
        logic [cht_pkg::COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[cht_pkg::COUNT_W] ? '1 : s[cht_pkg::COUNT_W-1:0];
    endfunction

    // state registers
    logic [cht_pkg::BPG_W-1:0]    r_bpg;
    logic [LW-1:0]                r_root;
    logic [LW-1:0]                r_used;
    logic [cht_pkg::COUNT_W-1:0]  r_sum;
    // per-item registers
    logic                         r_action;
    logic [cht_pkg::COLOR_W-1:0]  r_key;
    logic [cht_pkg::COUNT_W-1:0]  r_amount;
    logic [LW-1:0]                r_node;
    logic [LW-1:0]                r_parent;
    logic                         r_went_left;
    logic [1:0]                   r_ch;
    logic [2:0]                   r_sub;
    logic                         r_found;
    logic [cht_pkg::COUNT_W-1:0]  r_tally;
    logic [cht_pkg::STATUS_W-1:0] r_status;
    // output register
    logic                         r_out_valid;
    logic [cht_pkg::STATUS_W-1:0] r_out_status;
    logic [cht_pkg::COUNT_W-1:0]  r_out_count;
    logic [cht_pkg::DISTINCT_W-1:0] r_out_distinct;
    logic [cht_pkg::COUNT_W-1:0]  r_out_total;

    // memory ports
    logic [CTW-1:0] ct_rdata;
    logic [CTW-1:0] ct_wdata;
    logic [AW-1:0]  ct_waddr;
    logic           ct_we;
    logic [LW-1:0]  left_rdata;
    logic [LW-1:0]  right_rdata;
    logic [LW-1:0]  link_wdata;
    logic [AW-1:0]  link_waddr;
    logic           left_we;
    logic           right_we;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    // walk logic
    logic [cht_pkg::BPG_W-1:0]   bpg_eff;
    logic [2:0]                  last_sub;
    logic [7:0]                  chan_keep;
    logic [cht_pkg::COLOR_W-1:0] in_key;
    logic [7:0]                  key_byte;
    logic                        go_left;
    logic [LW-1:0]               next_link;
    logic [cht_pkg::COUNT_W-1:0] sum_next;
    logic [cht_pkg::COUNT_W-1:0] tally_next;
    logic [WW-1:0]               used_wide;

    always_comb begin
        if (r_bpg < cht_pkg::BPG_MIN) begin
            bpg_eff = cht_pkg::BPG_MIN;
        end else if (r_bpg > cht_pkg::BPG_MAX) begin
            bpg_eff = cht_pkg::BPG_MAX;
        end else begin
            bpg_eff = r_bpg;
        end
    end

    assign last_sub  = 3'(bpg_eff - 4'd1);
    assign chan_keep = ~(cht_pkg::CHAN_MASK >> bpg_eff);
    assign in_key    = i_color & {chan_keep, chan_keep, chan_keep};

    // tested bit: channel r_ch, bit (7 - r_sub) of it; clear once all kept bits used
    always_comb begin
        case (r_ch)
            2'd0:    key_byte = r_key[23:16];
            2'd1:    key_byte = r_key[15:8];
            2'd2:    key_byte = r_key[7:0];
            default: key_byte = 8'h00;
        endcase
    end

    assign go_left    = key_byte[~r_sub];
    assign next_link  = go_left ? left_rdata : right_rdata;
    assign sum_next   = sat_add(r_sum, r_amount);
    assign tally_next = sat_add(r_tally, r_amount);
    assign used_wide  = WW'(r_used);

    // node memory access
    assign rd_en   = i_cmd.load | i_cmd.step;
    assign rd_addr = i_cmd.load ? r_root[AW-1:0] : next_link[AW-1:0];

    assign ct_we    = i_cmd.bump | i_cmd.claim;
    assign ct_waddr = i_cmd.bump ? r_node[AW-1:0] : r_used[AW-1:0];
    assign ct_wdata = {r_key, (i_cmd.bump ? tally_next : r_amount)};

    assign link_waddr = i_cmd.claim ? r_used[AW-1:0] : r_parent[AW-1:0];
    assign link_wdata = i_cmd.claim ? NIL : r_used;
    assign left_we    = i_cmd.claim | (i_cmd.link && r_parent != NIL && r_went_left);
    assign right_we   = i_cmd.claim | (i_cmd.link && r_parent != NIL && !r_went_left);

    cht_ram #(.WIDTH(CTW), .DEPTH(NODE_COUNT)) u_ct_ram (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (ct_waddr),
        .i_wdata (ct_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ct_rdata)
    );

    cht_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (left_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (left_rdata)
    );

    cht_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (right_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (right_rdata)
    );

    // status to controller
    always_comb begin
        o_sts           = '0;
        o_sts.in_zero   = (i_action == cht_pkg::ACT_ADD) && (i_amount == '0);
        o_sts.node_ok   = r_node < r_used;
        o_sts.hit       = ct_rdata[CTW-1 -: cht_pkg::COLOR_W] == r_key;
        o_sts.is_query  = r_action == cht_pkg::ACT_QUERY;
        o_sts.found     = r_found;
        o_sts.pool_full = r_used >= NIL;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpg       <= cht_pkg::BPG_RESET;
            r_root      <= NIL;
            r_used      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bpg <= i_cfg_data;
            end
            if (i_cmd.bump) begin
                r_sum <= sum_next;
            end
            if (i_cmd.link) begin
                if (r_parent == NIL) begin
                    r_root <= r_used;
                end
                r_used <= r_used + 1'b1;
                r_sum  <= sum_next;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action    <= i_action;
            r_key       <= in_key;
            r_amount    <= i_amount;
            r_node      <= r_root;
            r_parent    <= NIL;
            r_went_left <= 1'b0;
            r_ch        <= 2'd0;
            r_sub       <= 3'd0;
            r_found     <= 1'b0;
            r_status    <= o_sts.in_zero ? cht_pkg::STAT_NODATA : cht_pkg::STAT_OK;
        end
        if (i_cmd.step) begin
            r_parent    <= r_node;
            r_went_left <= go_left;
            r_node      <= next_link;
            if (r_ch != 2'd3) begin
                if (r_sub == last_sub) begin
                    r_sub <= 3'd0;
                    r_ch  <= r_ch + 2'd1;
                end else begin
                    r_sub <= r_sub + 3'd1;
                end
            end
        end
        if (i_cmd.take_hit) begin
            r_found <= 1'b1;
            r_tally <= ct_rdata[cht_pkg::COUNT_W-1:0];
        end
        if (i_cmd.full) begin
            r_status <= cht_pkg::STAT_FULL;
        end
        if (i_cmd.emit) begin
            r_out_status   <= r_status;
            r_out_count    <= (r_action == cht_pkg::ACT_QUERY && r_found) ? r_tally : '0;
            r_out_distinct <= used_wide[cht_pkg::DISTINCT_W-1:0];
            r_out_total    <= r_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_distinct  = r_out_distinct;
    assign o_total     = r_out_total;

endmodule

// ----- hw/rtl/color_histogram_trie_top.sv -----
// Top level of the color histogram search tree.
//
// Counts pixels per color. Each input word either adds a pixel count for an RGB
// color or asks for the count of one; the color is first cut to the top
// bits_per_gun bits of each channel (4..8, reset 5, out-of-range values clamp).
// Colors sit in a pool of NODE_COUNT nodes linked as a digital search tree: the
// level-d node tests the d-th kept bit from bit 23 down, set goes left, clear
// goes right. Every input word returns exactly one result word carrying a status
// (ok, no data for an add of zero, table full), the queried count (zero for adds
// and absent colors), the number of distinct colors and the saturating pixel
// total. Timing: the walk reads one node per cycle through the registered read
// port of the node memories. After the walk an item passes an update step, then,
// for an add that claims a new node, a link step, and then waits in the result
// state until the output register is free; an add of zero goes straight to the
// result state. With 24 key bits and bits_per_gun unchanged since the nodes
// were stored, the walk reaches at most 25 nodes and a miss comes after at most
// 24; after bits_per_gun changes with nodes stored, walks past the kept bits run
// down right links and can take longer. One item is in work at a time; the next
// input word is taken while the last result still waits in the output register.
// The node memories need no clearing after reset: only nodes below the fill
// count are ever used. bits_per_gun is written on its own channel (always
// ready); the user must do so only while the block is idle, which the block
// itself does not enforce.
module color_histogram_trie_top #(
    parameter int NODE_COUNT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // pixel_color[23:0], add_amount[55:24]
    input  logic [0:0]  s_axis_tuser,   // action[0]
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // color_count[31:0], distinct_colors[44:32],
                                        // pixel_total[76:45], zero[79:77]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    // bits_per_gun write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    cht_pkg::t_cmd cmd;
    cht_pkg::t_sts sts;

    logic [cht_pkg::COUNT_W-1:0]    out_count;
    logic [cht_pkg::DISTINCT_W-1:0] out_distinct;
    logic [cht_pkg::COUNT_W-1:0]    out_total;

    assign o_cfg_ready = 1'b1;

    cht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    cht_dpath #(.NODE_COUNT(NODE_COUNT)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_action    (s_axis_tuser[0]),
        .i_color     (s_axis_tdata[23:0]),
        .i_amount    (s_axis_tdata[55:24]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_count     (out_count),
        .o_distinct  (out_distinct),
        .o_total     (out_total)
    );

    assign m_axis_tdata = {3'b000, out_total, out_distinct, out_count};

endmodule

// ----- hw/rtl/cht_checker.sv -----
// Port-level checks for the color histogram search tree, bound to the top level.
module cht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [79:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    // one item at a time: an accepted word closes the input side next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("input accepted while an item is in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)
                                         && $stable(i_m_tuser)))
        else $error("result changed while stalled");

    // only three status codes exist
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser == cht_pkg::STAT_OK
                        || i_m_tuser == cht_pkg::STAT_NODATA
                        || i_m_tuser == cht_pkg::STAT_FULL))
        else $error("unknown status code");

    // no-data and table-full results carry no count
    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && (i_m_tuser == cht_pkg::STAT_NODATA
                        || i_m_tuser == cht_pkg::STAT_FULL))
        |-> (i_m_tdata[31:0] == 32'd0))
        else $error("count set on a failed add");

endmodule

bind color_histogram_trie_top cht_checker u_cht_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
